// ===== hw/rtl/fip_pkg.sv =====
// ----------------------------------------------------------------------------
// fip_pkg
// Shared types, constants and helpers of the identifier permutation.
// ----------------------------------------------------------------------------
package fip_pkg;

  localparam logic [31:0] RADIX_B   = 32'h0001_0000;
  localparam logic [31:0] WALK_MARK = 32'hffff_0000;

  // MurmurHash3 x86_32 mixing constants
  localparam logic [31:0] MM_C1 = 32'hcc9e_2d51;
  localparam logic [31:0] MM_C2 = 32'h1b87_3593;
  localparam logic [31:0] MM_C3 = 32'h85eb_ca6b;
  localparam logic [31:0] MM_C4 = 32'hc2b2_ae35;
  localparam logic [31:0] MM_LEN = 32'd2;

  localparam logic [31:0] ROUND_SEED [4] = '{
    32'h4b38_7af7, 32'h85bc_ae01, 32'hee28_1300, 32'hb76d_5eed
  };

  // Halves of the Feistel state; the walk pass can push a half to 0x10001.
  typedef struct packed {
    logic [16:0] left;
    logic [16:0] right;
  } fip_half_t;

  // Data that rides along with an item through the rounds.
  typedef struct packed {
    logic [63:0] id;
    logic [31:0] c1;
  } fip_side_t;

  // Split m into quotient and remainder by 0xffff, swapping at the top quotient.
  // 2^16 == 1 mod 0xffff, so m = hi * 0xffff + (hi + lo).
  function automatic fip_half_t fip_split(input logic [31:0] m);
    logic [16:0] s;
    logic [16:0] q;
    logic [15:0] r;
    fip_half_t   h;
    s = {1'b0, m[31:16]} + {1'b0, m[15:0]};
    if (s == 17'h1_fffe) begin
      q = {1'b0, m[31:16]} + 17'd2;
      r = 16'd0;
    end else if (s >= 17'h0_ffff) begin
      q = {1'b0, m[31:16]} + 17'd1;
      r = 16'(s - 17'h0_ffff);
    end else begin
      q = {1'b0, m[31:16]};
      r = s[15:0];
    end
    if (q == 17'h0_ffff) begin
      h.left  = {1'b0, r};
      h.right = 17'h0_ffff;
    end else begin
      h.left  = q;
      h.right = {1'b0, r};
    end
    return h;
  endfunction

  // right * 0xffff + left; both halves hold 16-bit values after the rounds.
  function automatic logic [31:0] fip_join(input fip_half_t h);
    return {h.right[15:0], 16'h0000} - {16'h0000, h.right[15:0]}
           + {16'h0000, h.left[15:0]};
  endfunction

endpackage

// ===== hw/rtl/feistel_id_permute_top.sv =====
// ----------------------------------------------------------------------------
// feistel_id_permute_top
// Bijective scramble of a 64-bit identifier by a four-round Feistel cipher.
// Throughput: one identifier per cycle while the output is not stalled; 40 of
// the 45 stages are the eight unrolled hash rounds (five multiply-paced stages each).
// Reset clears all valid bits; the payload registers are not reset.
// ----------------------------------------------------------------------------
module feistel_id_permute_top
  import fip_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] identifier_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] scrambled_o
);

  // Stage map:
  //   A      split of (low word - 0x10000) into quotient/remainder by 0xffff
  //   R0-R3  first permutation pass, 5 stages per round
  //   B      join of first pass -> c1
  //   C      split of c1 for the cycle-walking pass
  //   R4-R7  second permutation pass, always computed
  //   D      join of second pass -> c2
  //   E      output register: pick bypass, or c1 or c2 with 0x10000 added back

  // The whole pipeline advances as one; it holds only while a beat sits in
  // the output register unclaimed. Bubbles upstream are not squeezed out during a hold.
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Stage A
  logic      vld_a_q;
  fip_half_t half_a_q;
  fip_side_t side_a_q;

  // Stage B / C / D / E
  logic        vld_b_q, vld_c_q, vld_d_q, vld_e_q;
  logic [31:0] c1_q, c2_q;
  fip_side_t   side_b_q, side_c_q, side_d_q;
  fip_half_t   half_c_q;
  logic [63:0] res_q;

  // Round chains
  logic [4:0]      r1_vld, r2_vld;
  fip_half_t [4:0] r1_half, r2_half;
  fip_side_t [4:0] r1_side, r2_side;

  assign r1_vld[0]  = vld_a_q;
  assign r1_half[0] = half_a_q;
  assign r1_side[0] = side_a_q;
  assign r2_vld[0]  = vld_c_q;
  assign r2_half[0] = half_c_q;
  assign r2_side[0] = side_c_q;

  for (genvar i = 0; i < 4; i++) begin : g_pass1
    fip_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .rnd_i  (2'(i)),
      .valid_i(r1_vld[i]),
      .half_i (r1_half[i]),
      .side_i (r1_side[i]),
      .valid_o(r1_vld[i+1]),
      .half_o (r1_half[i+1]),
      .side_o (r1_side[i+1])
    );
  end

  for (genvar i = 0; i < 4; i++) begin : g_pass2
    fip_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .rnd_i  (2'(i)),
      .valid_i(r2_vld[i]),
      .half_i (r2_half[i]),
      .side_i (r2_side[i]),
      .valid_o(r2_vld[i+1]),
      .half_o (r2_half[i+1]),
      .side_o (r2_side[i+1])
    );
  end

  // Output select: a low word below 0x10000 passes as is; a first-pass result
  // in the top 0x10000 values takes the second pass (cycle walking).
  logic        bypass, walk;
  logic [31:0] low_d;

  always_comb begin
    bypass = (side_d_q.id[31:16] == 16'h0000);
    walk   = (side_d_q.c1 >= WALK_MARK);
    if (bypass) begin
      low_d = side_d_q.id[31:0];
    end else if (walk) begin
      low_d = c2_q + RADIX_B;
    end else begin
      low_d = side_d_q.c1 + RADIX_B;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
    end else if (adv) begin
      vld_a_q <= in_valid_i;
      vld_b_q <= r1_vld[4];
      vld_c_q <= vld_b_q;
      vld_d_q <= r2_vld[4];
      vld_e_q <= vld_d_q;
    end
  end

  // Payload; no reset needed
  always_ff @(posedge clk_i) begin
    if (adv) begin
      half_a_q    <= fip_split(identifier_i[31:0] - RADIX_B);
      side_a_q.id <= identifier_i;
      side_a_q.c1 <= '0;

      c1_q        <= fip_join(r1_half[4]);
      side_b_q    <= r1_side[4];

      half_c_q    <= fip_split(c1_q);
      side_c_q.id <= side_b_q.id;
      side_c_q.c1 <= c1_q;

      c2_q        <= fip_join(r2_half[4]);
      side_d_q    <= r2_side[4];

      res_q       <= {side_d_q.id[63:32], low_d};
    end
  end

  assign out_valid_o = vld_e_q;
  assign scrambled_o = res_q;

  a_hold_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input held back without an output stall");

  a_split_swapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_a_q |-> half_a_q.left != 17'h0_ffff && !half_a_q.right[16])
    else $error("first split left the top quotient unswapped");

  a_walk_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_c_q && (side_c_q.c1 >= WALK_MARK) |-> half_c_q.left[16])
    else $error("walk pass quotient below 0x10000");

endmodule

// ===== hw/rtl/fip_round.sv =====
// ----------------------------------------------------------------------------
// fip_round
// One Feistel round: a two-byte MurmurHash3 in four multiply stages and a
// modular combine stage. Five register stages, one item per cycle while en_i is high.
// ----------------------------------------------------------------------------
module fip_round
  import fip_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic [1:0] rnd_i,
  input  logic      valid_i,
  input  fip_half_t half_i,
  input  fip_side_t side_i,
  output logic      valid_o,
  output fip_half_t half_o,
  output fip_side_t side_o
);

  logic [4:0]      vld_q;
  fip_half_t [4:0] half_q;
  fip_side_t [4:0] side_q;
  logic [31:0]     p1_q, p2_q, p3_q, p4_q;

  logic [31:0] p1_d, p2_d, p3_d, p4_d;
  logic [31:0] k2, h3, h3x, h4, f;
  logic [16:0] fs;
  logic [15:0] ft, fm;
  logic [17:0] x;
  logic [15:0] tmp;
  fip_half_t   half_d;

  always_comb begin
    p1_d = {16'h0000, half_i.left[15:0]} * MM_C1;
    k2   = {p1_q[16:0], p1_q[31:17]};
    p2_d = k2 * MM_C2;
    h3   = ROUND_SEED[rnd_i] ^ p2_q ^ MM_LEN;
    h3x  = h3 ^ (h3 >> 16);
    p3_d = h3x * MM_C3;
    h4   = p3_q ^ (p3_q >> 13);
    p4_d = h4 * MM_C4;
    f    = p4_q ^ (p4_q >> 16);

    // f mod 0xffff by end-around fold
    fs = {1'b0, f[31:16]} + {1'b0, f[15:0]};
    ft = fs[15:0] + {15'd0, fs[16]};
    fm = (ft == 16'hffff) ? 16'h0000 : ft;
    x  = {1'b0, half_q[3].right} + 18'h0_ffff - {2'b00, fm};

    if (rnd_i[0]) begin
      if (x >= 18'h1_fffe) begin
        tmp = 16'(x - 18'h1_fffe);
      end else if (x >= 18'h0_ffff) begin
        tmp = 16'(x - 18'h0_ffff);
      end else begin
        tmp = x[15:0];
      end
    end else begin
      tmp = half_q[3].right[15:0] - f[15:0];
    end
    half_d.left  = {1'b0, tmp};
    half_d.right = half_q[3].left;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      half_q <= {half_d, half_q[2:0], half_i};
      side_q <= {side_q[3:0], side_i};
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      p3_q   <= p3_d;
      p4_q   <= p4_d;
    end
  end

  assign valid_o = vld_q[4];
  assign half_o  = half_q[4];
  assign side_o  = side_q[4];

  a_odd_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] && rnd_i[0] |-> half_q[4].left < 17'h0_ffff)
    else $error("odd round result not reduced below 0xffff");

  a_right_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> half_q[4].right <= 17'h1_0001)
    else $error("round right half out of range");

endmodule
